FILE: rtl/fts_pkg.sv
// Package for the flow traffic statistics table: codes, constants, table entry types
// and the sequencer state type. It depends on nothing else.
`default_nettype none

package fts_pkg;

   localparam int          TABLE_DEPTH    = 32;
   localparam logic [15:0] IPV4_TYPE      = 16'h0800;
   localparam logic [15:0] INTERVAL_RESET = 16'd60;
   localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;

   localparam logic REQ_FRAME = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   typedef struct packed {
      logic [47:0] src_mac;
      logic [47:0] dst_mac;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
   } flow_key_type;

   typedef struct packed {
      flow_key_type key;
      logic [31:0]  bytes;
      logic [31:0]  packets;
   } flow_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_MISS,
      ST_CHECK,
      ST_RPT_RD,
      ST_RPT_LOAD,
      ST_RPT_SEND
   } fts_state_type;

endpackage

`default_nettype wire

FILE: rtl/fts_if.sv
// Channel interfaces of the flow traffic statistics table: request, response and
// configuration write. They depend on nothing else.
`default_nettype none

interface fts_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [15:0] eth_type;
   logic [47:0] source_mac;
   logic [47:0] dst_mac;
   logic [31:0] source_ip;
   logic [31:0] dest_ip;
   logic [15:0] frame_len;

   modport source (output valid, req_type, eth_type, source_mac, dst_mac,
                   source_ip, dest_ip, frame_len, input ready);
   modport sink   (input valid, req_type, eth_type, source_mac, dst_mac,
                   source_ip, dest_ip, frame_len, output ready);
endinterface

interface fts_rsp_if;
   logic        valid;
   logic        ready;
   logic [47:0] out_source_mac;
   logic [47:0] out_dst_mac;
   logic [31:0] out_source_ip;
   logic [31:0] out_dest_ip;
   logic [31:0] byte_total;
   logic [31:0] packet_total;
   logic        last_entry;

   modport source (output valid, out_source_mac, out_dst_mac, out_source_ip,
                   out_dest_ip, byte_total, packet_total, last_entry, input ready);
   modport sink   (input valid, out_source_mac, out_dst_mac, out_source_ip,
                   out_dest_ip, byte_total, packet_total, last_entry, output ready);
endinterface

interface fts_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] report_interval;

   modport source (output valid, report_interval, input ready);
   modport sink   (input valid, report_interval, output ready);
endinterface

`default_nettype wire

FILE: rtl/flow_traffic_stats_table.sv
// Top level of the flow traffic statistics table: sequencer, table RAM and match unit.
// It depends on fts_pkg, the channel interfaces, fts_ram and fts_match.
//
// A tick request is taken while idle and leaves the sequencer idle. A frame request holds
// the request channel off while the sequencer walks the table through the single read port
// of the RAM, reading (ST_SCAN_RD) and then comparing (ST_SCAN_CMP) each valid entry in
// the one shared match unit; any frame that is not IPv4 skips the walk. When the
// elapsed tick count has reached report_interval after a frame, each valid entry is read
// and sent as one response transfer (ST_RPT_RD, ST_RPT_LOAD, ST_RPT_SEND, held there while
// the response stalls), the last one flagged by last_entry; then the table and the
// tick count are cleared. Table storage has no reset; only the fill count is cleared.
// The configuration channel is always ready and takes the new interval at once.
`default_nettype none

module flow_traffic_stats_table #(
   parameter int TABLE_DEPTH = fts_pkg::TABLE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   fts_req_if.sink    req_bus,
   fts_rsp_if.source  rsp_bus,
   fts_csr_if.sink    csr_bus
);

   localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W = $bits(fts_pkg::flow_entry_type);

   fts_pkg::fts_state_type  state_ff, state_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]        used_ff, used_in;
   logic [15:0]             elapsed_ff, elapsed_in;
   logic [15:0]             interval_ff;
   fts_pkg::flow_key_type   key_ff, key_in;
   logic [15:0]             len_ff, len_in;
   fts_pkg::flow_entry_type rsp_entry_ff, rsp_entry_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   fts_pkg::flow_entry_type wr_entry;
   logic                    rd_en;
   logic [ENTRY_W-1:0]      rd_data;
   fts_pkg::flow_entry_type rd_entry;
   logic                    hit;
   fts_pkg::flow_entry_type hit_entry;
   fts_pkg::flow_entry_type new_entry;
   logic                    idx_is_last;

   assign rd_entry    = fts_pkg::flow_entry_type'(rd_data);
   assign idx_is_last = ((idx_ff + CNT_W'(1)) == used_ff);

   fts_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH),
      .ADDR_W(IDX_W)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_en  (rd_en),
      .rd_addr(idx_ff[IDX_W-1:0]),
      .rd_data(rd_data)
   );

   fts_match u_match (
      .entry    (rd_entry),
      .key      (key_ff),
      .frame_len(len_ff),
      .hit      (hit),
      .hit_entry(hit_entry),
      .new_entry(new_entry)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fts_pkg::ST_IDLE;
         idx_ff       <= '0;
         used_ff      <= '0;
         elapsed_ff   <= '0;
         interval_ff  <= fts_pkg::INTERVAL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         used_ff      <= used_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid) begin
            interval_ff <= csr_bus.report_interval;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      len_ff       <= len_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      used_in      = used_ff;
      elapsed_in   = elapsed_ff;
      key_in       = key_ff;
      len_in       = len_ff;
      rsp_entry_in = rsp_entry_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[IDX_W-1:0];
      wr_entry     = hit_entry;
      rd_en        = 1'b0;

      case (state_ff)
         fts_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               key_in.src_mac = req_bus.source_mac;
               key_in.dst_mac = req_bus.dst_mac;
               key_in.src_ip  = req_bus.source_ip;
               key_in.dst_ip  = req_bus.dest_ip;
               len_in         = req_bus.frame_len;
               idx_in         = '0;
               if (req_bus.req_type == fts_pkg::REQ_TICK) begin
                  if (elapsed_ff != fts_pkg::ELAPSED_MAX) begin
                     elapsed_in = elapsed_ff + 16'd1;
                  end
               end else if (req_bus.eth_type != fts_pkg::IPV4_TYPE) begin
                  state_in = fts_pkg::ST_CHECK;
               end else if (used_ff == '0) begin
                  state_in = fts_pkg::ST_MISS;
               end else begin
                  state_in = fts_pkg::ST_SCAN_RD;
               end
            end
         end
         fts_pkg::ST_SCAN_RD: begin
            rd_en    = 1'b1;
            state_in = fts_pkg::ST_SCAN_CMP;
         end
         fts_pkg::ST_SCAN_CMP: begin
            if (hit) begin
               wr_en    = 1'b1;
               state_in = fts_pkg::ST_CHECK;
            end else if (idx_is_last) begin
               state_in = fts_pkg::ST_MISS;
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = fts_pkg::ST_SCAN_RD;
            end
         end
         fts_pkg::ST_MISS: begin
            wr_addr  = used_ff[IDX_W-1:0];
            wr_entry = new_entry;
            if (used_ff < CNT_W'(TABLE_DEPTH)) begin
               wr_en   = 1'b1;
               used_in = used_ff + CNT_W'(1);
            end
            state_in = fts_pkg::ST_CHECK;
         end
         fts_pkg::ST_CHECK: begin
            idx_in = '0;
            if (elapsed_ff < interval_ff) begin
               state_in = fts_pkg::ST_IDLE;
            end else if (used_ff == '0) begin
               elapsed_in = '0;
               state_in   = fts_pkg::ST_IDLE;
            end else begin
               state_in = fts_pkg::ST_RPT_RD;
            end
         end
         fts_pkg::ST_RPT_RD: begin
            rd_en    = 1'b1;
            state_in = fts_pkg::ST_RPT_LOAD;
         end
         fts_pkg::ST_RPT_LOAD: begin
            rsp_entry_in = rd_entry;
            rsp_last_in  = idx_is_last;
            rsp_valid_in = 1'b1;
            state_in     = fts_pkg::ST_RPT_SEND;
         end
         fts_pkg::ST_RPT_SEND: begin
            if (rsp_bus.ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  used_in    = '0;
                  elapsed_in = '0;
                  state_in   = fts_pkg::ST_IDLE;
               end else begin
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = fts_pkg::ST_RPT_RD;
               end
            end
         end
         default: begin
            state_in = fts_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_bus.ready          = (state_ff == fts_pkg::ST_IDLE);
   assign csr_bus.ready          = 1'b1;
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.out_source_mac = rsp_entry_ff.key.src_mac;
   assign rsp_bus.out_dst_mac    = rsp_entry_ff.key.dst_mac;
   assign rsp_bus.out_source_ip  = rsp_entry_ff.key.src_ip;
   assign rsp_bus.out_dest_ip    = rsp_entry_ff.key.dst_ip;
   assign rsp_bus.byte_total     = rsp_entry_ff.bytes;
   assign rsp_bus.packet_total   = rsp_entry_ff.packets;
   assign rsp_bus.last_entry     = rsp_last_ff;

endmodule

`default_nettype wire

FILE: rtl/fts_ram.sv
// Generic single write port, single read port RAM with a registered read.
// It depends on nothing else.
`default_nettype none

module fts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/fts_match.sv
// Shared key compare and counter update unit for one table entry.
// It depends on fts_pkg for the entry types.
`default_nettype none

module fts_match (
   input  fts_pkg::flow_entry_type entry,
   input  fts_pkg::flow_key_type   key,
   input  logic [15:0]             frame_len,
   output logic                    hit,
   output fts_pkg::flow_entry_type hit_entry,
   output fts_pkg::flow_entry_type new_entry
);

   always_comb begin
      hit               = (entry.key == key);
      hit_entry.key     = entry.key;
      hit_entry.bytes   = entry.bytes + {16'd0, frame_len};
      hit_entry.packets = entry.packets + 32'd1;
      new_entry.key     = key;
      new_entry.bytes   = {16'd0, frame_len};
      new_entry.packets = 32'd1;
   end

endmodule

`default_nettype wire

FILE: rtl/fts_checker.sv
// Port-level checker for the flow traffic statistics table and its bind statement.
// It depends on fts_pkg for the request codes and on the top level's channel ports.
`default_nettype none

module fts_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_type,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] byte_total,
   input logic [31:0] packet_total,
   input logic [31:0] out_source_ip,
   input logic        last_entry
);

   // A stalled response holds its contents until the transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(byte_total) &&
      $stable(packet_total) && $stable(out_source_ip) && $stable(last_entry))
      else $error("stalled response changed");

   // No request is taken while a report entry is pending.
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request ready during a report");

   // Each report entry is fetched anew after a transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("response valid right after a transfer");

   // A frame transfer keeps the request channel busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_type == fts_pkg::REQ_FRAME) |=> !req_ready)
      else $error("request ready right after a frame");

endmodule

bind flow_traffic_stats_table fts_checker u_fts_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .req_type     (req_bus.req_type),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .byte_total   (rsp_bus.byte_total),
   .packet_total (rsp_bus.packet_total),
   .out_source_ip(rsp_bus.out_source_ip),
   .last_entry   (rsp_bus.last_entry)
);

`default_nettype wire
